// File: rtl/core/pcr_pkg.sv
package pcr_pkg;

	// Fixed field widths
	localparam int VAL_W = 10;
	localparam int CNT_W = 11;
	localparam int CMD_W = 2;

	// Command codes carried in s_tuser
	localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PARENT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FILL   = 2'd2;

	// Configuration register indexes
	localparam logic REG_HIGHEST = 1'b0;
	localparam logic REG_LENGTH  = 1'b1;

	// One input beat, unpacked
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] mom;
		logic [VAL_W-1:0] dad;
		logic [VAL_W-1:0] split;
		logic [VAL_W-1:0] rnd;
	} item_t;

	// Effective limits after clamping to the build-time sizes
	typedef struct packed {
		logic [VAL_W-1:0] high;
		logic [CNT_W-1:0] len;
	} lim_t;

	// One result beat offered to the output register
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             error;
	} res_t;

endpackage

// File: rtl/core/pcr_ram.sv
module pcr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/pcr_ctrl.sv
module pcr_ctrl #(
	parameter int VALUE_SPACE = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pcr_pkg::item_t item,
	input  pcr_pkg::lim_t  lim,
	output pcr_pkg::res_t  res,
	input  logic          res_take
);

	import pcr_pkg::*;

	localparam int AW = $clog2(VALUE_SPACE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(VALUE_SPACE - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAR_CHK,
		ST_FILL_CHK,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] split_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] tries_q;
	logic [AW-1:0]    clr_q;
	logic             err_q;

	logic [VAL_W-1:0] chosen;
	logic [VAL_W-1:0] next_val;
	logic             used;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic             ram_rdata;

	// Pick the parent gene and the next probe value (wrap after highest)
	assign chosen   = (pos_q <= {1'b0, split_q}) ? item.mom : item.dad;
	assign next_val = (val_q >= lim.high) ? '0 : val_q + 1'b1;
	assign used     = ram_rdata;

	// Used-value map port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(val_q);
		ram_wdata = 1'b1;
		ram_raddr = AW'(val_q);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
			end
			ST_IDLE: begin
				ram_raddr = (item.cmd == CMD_FILL) ? AW'(item.rnd) : AW'(chosen);
			end
			ST_PAR_CHK: begin
				ram_we = !used && (cnt_q < lim.len);
			end
			ST_FILL_CHK: begin
				ram_we    = !used;
				ram_raddr = AW'(next_val);
			end
			ST_EMIT: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pcr_ram #(
		.WIDTH(1),
		.DEPTH(VALUE_SPACE)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer: clear sweep, map read-check-mark, probe loop, result hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pos_q   <= '0;
			cnt_q   <= '0;
			split_q <= '0;
			val_q   <= '0;
			tries_q <= '0;
			clr_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (item.cmd)
							CMD_START: begin
								split_q <= item.split;
								pos_q   <= '0;
								cnt_q   <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_PARENT: begin
								if (pos_q >= lim.len) begin
									err_q   <= 1'b1;
									state_q <= ST_EMIT;
								end else begin
									pos_q <= pos_q + 1'b1;
									val_q <= chosen;
									if (chosen > lim.high) begin
										err_q   <= 1'b1;
										state_q <= ST_EMIT;
									end else begin
										err_q   <= 1'b0;
										state_q <= ST_PAR_CHK;
									end
								end
							end
							CMD_FILL: begin
								if (cnt_q >= lim.len || item.rnd > lim.high) begin
									err_q   <= 1'b1;
									state_q <= ST_EMIT;
								end else begin
									err_q   <= 1'b0;
									val_q   <= item.rnd;
									tries_q <= '0;
									state_q <= ST_FILL_CHK;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PAR_CHK: begin
					if (used) begin
						state_q <= ST_IDLE;
					end else begin
						err_q   <= (cnt_q >= lim.len);
						state_q <= ST_EMIT;
					end
				end
				ST_FILL_CHK: begin
					if (!used) begin
						err_q   <= 1'b0;
						state_q <= ST_EMIT;
					end else if (tries_q == lim.high) begin
						err_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						val_q   <= next_val;
						tries_q <= tries_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (res_take) begin
						if (!err_q) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign res.valid   = (state_q == ST_EMIT);
	assign res.index   = err_q ? '0 : cnt_q[VAL_W-1:0];
	assign res.value   = err_q ? '0 : val_q;
	assign res.error   = err_q;

	// Only in-range values are ever marked
	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q == ST_PAR_CHK || state_q == ST_FILL_CHK) |-> val_q <= lim.high)
		else $error("map mark beyond highest value");

	// A served parent beat advances the parent position by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && item.cmd == CMD_PARENT && pos_q < lim.len
		|=> pos_q == CNT_W'($past(pos_q) + 1'b1))
		else $error("parent position did not advance");

	// A delivered good gene advances the child count by one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && res.valid && !res.error |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("child count did not advance");

	// The probe loop never runs past one full lap
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL_CHK |-> tries_q <= lim.high)
		else $error("probe count beyond lap");

	// A start beat always begins a clear sweep at the first entry
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && item.cmd == CMD_START |=> state_q == ST_CLEAR && clr_q == '0)
		else $error("start did not begin clear sweep");

endmodule

// File: rtl/core/permutation_crossover_repair_top.sv
// Channel | Direction | Beat contents
// s_*     | in        | tuser: command; tdata: mom, dad, crossover point, random start
// m_*     | out       | tuser: error; tdata: child index, child value
// cfg_*   | in        | cfg_index selects highest value (0) or genome length (1)
//
// Parent beat: accept, map read, result. Used gene: no result. Early error: no map read.
// A fill beat probes upward from the random start, wrapping, at most VALUE_SPACE probes.
// A start beat clears the used map one entry a cycle, over every entry.
// After reset the same clear sweep runs before s_tready rises.
// The map takes one write and one registered read a cycle; a result waits
// in the output register while the next beat is accepted; m_tready stalls hold it there.
module permutation_crossover_repair_top #(
	parameter int VALUE_SPACE = 1024,
	parameter int MAX_GENES   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // mom_gene, dad_gene, crossover_pos, random_start
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // child_index, child_value, zero pad
	output logic        m_tuser,   // error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	import pcr_pkg::*;

	logic [VAL_W-1:0] high_q;
	logic [CNT_W-1:0] len_q;
	logic             m_valid_q;
	logic [VAL_W-1:0] m_index_q;
	logic [VAL_W-1:0] m_value_q;
	logic             m_error_q;

	item_t item;
	lim_t  lim;
	res_t  res;
	logic  res_take;

	// Configuration writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= VAL_W'(1023);
			len_q  <= CNT_W'(1024);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HIGHEST: high_q <= cfg_data[VAL_W-1:0];
				REG_LENGTH:  len_q  <= cfg_data;
				default:     len_q  <= len_q;
			endcase
		end
	end

	// Clamp limits to the build-time sizes
	assign lim.high = (32'(high_q) < VALUE_SPACE - 1) ? high_q : VAL_W'(VALUE_SPACE - 1);
	assign lim.len  = (32'(len_q) < MAX_GENES) ? len_q : CNT_W'(MAX_GENES);

	// Unpack the input beat
	assign item.cmd   = s_tuser;
	assign item.mom   = s_tdata[9:0];
	assign item.dad   = s_tdata[19:10];
	assign item.split = s_tdata[29:20];
	assign item.rnd   = s_tdata[39:30];

	pcr_ctrl #(
		.VALUE_SPACE(VALUE_SPACE)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.item    (item),
		.lim     (lim),
		.res     (res),
		.res_take(res_take)
	);

	// Output register: load when empty or being drained
	assign res_take = res.valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_index_q <= res.index;
			m_value_q <= res.value;
			m_error_q <= res.error;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_value_q, m_index_q};
	assign m_tuser  = m_error_q;

endmodule
